>>> sv/wps_pkg.sv
`timescale 1ns / 1ps

package wps_pkg;

    // payload widths
    localparam int COLOR_W    = 24;
    localparam int IDX_W      = 3;
    localparam int TICK_W     = 10;
    localparam int LONG_W     = 16;
    localparam int LEN_W      = 4;
    localparam int BITPOS_W   = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // first bit sent of a color word (green msb)
    localparam logic [BITPOS_W-1:0] COLOR_MSB = BITPOS_W'(COLOR_W - 1);

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_START = 2'd2
    } t_req_type;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ONE_LOW   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAP       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIX_CNT   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LEN   = 3'd6;

    // register reset values
    localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 10'd140;
    localparam logic [TICK_W-1:0] RST_ONE_LOW   = 10'd160;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 10'd70;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 10'd120;
    localparam logic [LONG_W-1:0] RST_GAP       = 16'd12000;
    localparam logic [LONG_W-1:0] RST_PIX_CNT   = 16'd8;
    localparam logic [LEN_W-1:0]  RST_PAT_LEN   = 4'd1;

endpackage

>>> sv/wps_if.sv
`timescale 1ns / 1ps

// request word channel
interface wps_req_if import wps_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_req_type            req_type;
    logic [IDX_W-1:0]     entry_index;
    logic [COLOR_W-1:0]   entry_color;

    modport source (output valid, output req_type, output entry_index,
                    output entry_color, input ready);
    modport sink   (input valid, input req_type, input entry_index,
                    input entry_color, output ready);
endinterface

// result word channel
interface wps_res_if import wps_pkg::*; ();
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic accepted;

    modport source (output valid, output line_level, output busy_res,
                    output frame_done, output accepted, input ready);
    modport sink   (input valid, input line_level, input busy_res,
                    input frame_done, input accepted, output ready);
endinterface

>>> sv/ws2812_pixel_waveform_sender.sv
// serial encoder for a one-wire addressable led chain
// request channel i_req carries one word per line cycle or command:
//   tick  - advance the waveform and report the line level
//   load  - write a 24-bit grb color into pattern entry entry_index (idle only)
//   start - begin a frame of pixel_count pixels, then a low latch gap (idle only)
// result channel o_res returns exactly one word per request word:
//   line_level, busy_res (frame or gap still running), frame_done (last gap
//   tick), accepted (load or start taken)
// pixel p shows pattern entry p mod pattern_length, msb first; bit timing and
// gap length come from the configuration registers, to be written only while idle; the block does not enforce this
// throughput: one request word per clock, sustained while the receiver takes every result word
// the result word is registered and valid in the clock after its request is taken
// the result sits in one output register; a request is taken whenever that
// register is empty or drained in the same clock, so a stalled receiver
// stalls the request side after one word
// reset (i_rst_n low, synchronous): idle, output empty, registers at their
// defaults; pattern entries hold garbage until loaded
`timescale 1ns / 1ps

module ws2812_pixel_waveform_sender import wps_pkg::*; #(
    parameter int PATTERN_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wps_req_if.sink               i_req,
    wps_res_if.source             o_res,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data
);

    // only entries reachable by the 3-bit load index are stored
    localparam int STORE_DEPTH = (PATTERN_DEPTH < (1 << IDX_W)) ? PATTERN_DEPTH
                                                                : (1 << IDX_W);
    localparam int SIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    // longest pattern the 4-bit length register can select
    localparam int LEN_MAX     = (1 << LEN_W) - 1;
    localparam int MAX_LEN     = (PATTERN_DEPTH < LEN_MAX) ? PATTERN_DEPTH : LEN_MAX;
    localparam int POS_W       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW          = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_LEN);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } t_phase;

    function automatic logic [LONG_W-1:0] f_min1(input logic [LONG_W-1:0] v);
        return (v == '0) ? LONG_W'(1) : v;
    endfunction

    // configuration registers
    logic [TICK_W-1:0] r_one_high, r_one_low, r_zero_high, r_zero_low;
    logic [LONG_W-1:0] r_gap, r_pix_cnt;
    logic [LEN_W-1:0]  r_pat_len;

    // pattern store, no reset
    logic [COLOR_W-1:0] r_store [STORE_DEPTH];

    // frame state
    t_phase              r_phase, n_phase;
    logic [LONG_W-1:0]   r_ticks, n_ticks;
    logic [LONG_W-1:0]   r_pix, n_pix;
    logic [POS_W-1:0]    r_pat, n_pat;
    logic [BITPOS_W-1:0] r_bit, n_bit;
    logic                r_cur_bit, n_cur_bit;

    // output register
    logic r_out_valid;
    logic r_level, r_busy, r_done, r_acc;

    logic                take;
    logic                level, done, acc, store_we;
    logic                enter_high;
    logic [LONG_W-1:0]   ticks_base;
    logic [POS_W-1:0]    rd_pos;
    logic [BITPOS_W-1:0] rd_bit;
    logic [COLOR_W-1:0]  rd_color;
    logic                new_bit;
    logic [LONG_W-1:0]   dec;
    logic [LONG_W-1:0]   pix_inc;
    logic [CW-1:0]       pat_inc;
    logic [CW-1:0]       eff_len;
    logic [LEN_W-1:0]    len_sat;

    assign take        = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_valid || o_res.ready;

    assign o_res.valid      = r_out_valid;
    assign o_res.line_level = r_level;
    assign o_res.busy_res   = r_busy;
    assign o_res.frame_done = r_done;
    assign o_res.accepted   = r_acc;

    // effective pattern length: zero acts as one, capped at PATTERN_DEPTH
    assign len_sat = (r_pat_len == '0) ? LEN_W'(1)
                   : ((int'(r_pat_len) > PATTERN_DEPTH) ? LEN_CAP : r_pat_len);
    assign eff_len = CW'(len_sat);
    assign pat_inc = CW'(r_pat) + CW'(1);
    assign pix_inc = r_pix + LONG_W'(1);
    assign dec     = r_ticks - LONG_W'(1);

    // single read of the store, at the position the next high phase uses
    assign rd_color = (int'(rd_pos) < STORE_DEPTH) ? r_store[rd_pos[SIDX_W-1:0]]
                                                   : '0;
    assign new_bit  = rd_color[rd_bit];

    always_comb begin
        n_phase    = r_phase;
        ticks_base = r_ticks;
        n_pix      = r_pix;
        n_pat      = r_pat;
        n_bit      = r_bit;
        level      = 1'b0;
        done       = 1'b0;
        acc        = 1'b0;
        store_we   = 1'b0;
        enter_high = 1'b0;
        rd_pos     = r_pat;
        rd_bit     = r_bit;
        if (take) begin
            case (i_req.req_type)
                REQ_TICK: begin
                    case (r_phase)
                        PH_HIGH: begin
                            level      = 1'b1;
                            ticks_base = dec;
                            if (dec == '0) begin
                                n_phase    = PH_LOW;
                                ticks_base = f_min1(LONG_W'(r_cur_bit ? r_one_low
                                                                      : r_zero_low));
                            end
                        end
                        PH_LOW: begin
                            ticks_base = dec;
                            if (dec == '0) begin
                                if (r_bit != '0 && r_bit <= COLOR_MSB) begin
                                    // next bit of the same pixel
                                    n_bit      = r_bit - BITPOS_W'(1);
                                    rd_bit     = n_bit;
                                    enter_high = 1'b1;
                                end else begin
                                    // pixel finished
                                    n_bit  = COLOR_MSB;
                                    n_pix  = pix_inc;
                                    n_pat  = (pat_inc >= eff_len) ? '0 : pat_inc[POS_W-1:0];
                                    rd_pos = n_pat;
                                    rd_bit = COLOR_MSB;
                                    if (pix_inc >= r_pix_cnt || pix_inc == '0) begin
                                        n_phase    = PH_GAP;
                                        ticks_base = f_min1(r_gap);
                                    end else begin
                                        enter_high = 1'b1;
                                    end
                                end
                            end
                        end
                        PH_GAP: begin
                            ticks_base = dec;
                            if (dec == '0) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end
                        end
                        default: begin
                            // idle tick: line low, nothing moves
                        end
                    endcase
                end
                REQ_LOAD: begin
                    if (r_phase == PH_IDLE && int'(i_req.entry_index) < STORE_DEPTH) begin
                        store_we = 1'b1;
                        acc      = 1'b1;
                    end
                end
                REQ_START: begin
                    if (r_phase == PH_IDLE) begin
                        acc    = 1'b1;
                        n_pix  = '0;
                        n_pat  = '0;
                        n_bit  = COLOR_MSB;
                        rd_pos = '0;
                        rd_bit = COLOR_MSB;
                        if (r_pix_cnt == '0) begin
                            n_phase    = PH_GAP;
                            ticks_base = f_min1(r_gap);
                        end else begin
                            enter_high = 1'b1;
                        end
                    end
                end
                default: begin
                    // unused request code, ignored
                end
            endcase
        end
        if (enter_high) begin
            n_phase = PH_HIGH;
        end
    end

    // high phase entry takes its length from the bit it starts
    always_comb begin
        n_cur_bit = r_cur_bit;
        n_ticks   = ticks_base;
        if (enter_high) begin
            n_cur_bit = new_bit;
            n_ticks   = f_min1(LONG_W'(new_bit ? r_one_high : r_zero_high));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ticks     <= '0;
            r_pix       <= '0;
            r_pat       <= '0;
            r_bit       <= COLOR_MSB;
            r_cur_bit   <= 1'b0;
            r_out_valid <= 1'b0;
            r_one_high  <= RST_ONE_HIGH;
            r_one_low   <= RST_ONE_LOW;
            r_zero_high <= RST_ZERO_HIGH;
            r_zero_low  <= RST_ZERO_LOW;
            r_gap       <= RST_GAP;
            r_pix_cnt   <= RST_PIX_CNT;
            r_pat_len   <= RST_PAT_LEN;
        end else begin
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_pix     <= n_pix;
            r_pat     <= n_pat;
            r_bit     <= n_bit;
            r_cur_bit <= n_cur_bit;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_ONE_HIGH:  r_one_high  <= i_cfg_wr_data[TICK_W-1:0];
                    CFG_ONE_LOW:   r_one_low   <= i_cfg_wr_data[TICK_W-1:0];
                    CFG_ZERO_HIGH: r_zero_high <= i_cfg_wr_data[TICK_W-1:0];
                    CFG_ZERO_LOW:  r_zero_low  <= i_cfg_wr_data[TICK_W-1:0];
                    CFG_GAP:       r_gap       <= i_cfg_wr_data;
                    CFG_PIX_CNT:   r_pix_cnt   <= i_cfg_wr_data;
                    CFG_PAT_LEN:   r_pat_len   <= i_cfg_wr_data[LEN_W-1:0];
                    default: begin
                        // unmapped index, dropped
                    end
                endcase
            end
        end
        // payload, no reset
        if (take) begin
            r_level <= level;
            r_busy  <= (n_phase != PH_IDLE);
            r_done  <= done;
            r_acc   <= acc;
        end
        if (store_we) begin
            r_store[i_req.entry_index[SIDX_W-1:0]] <= i_req.entry_color;
        end
    end

endmodule

>>> sv/wps_checker.sv
`timescale 1ns / 1ps

module wps_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_line_level,
    input logic i_busy_res,
    input logic i_frame_done,
    input logic i_accepted
);

    // a result word waits until taken
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // a high line only happens inside a frame
    a_high_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_line_level |-> i_busy_res)
        else $error("line high while not busy");

    // the gap end leaves the sender idle with the line low
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_done |-> !i_busy_res && !i_line_level && !i_accepted)
        else $error("frame done while still busy");

    // commands never move the line
    a_cmd_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_accepted |-> !i_line_level && !i_frame_done)
        else $error("accepted command reported a line cycle");

endmodule

bind ws2812_pixel_waveform_sender wps_checker u_wps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_line_level (o_res.line_level),
    .i_busy_res   (o_res.busy_res),
    .i_frame_done (o_res.frame_done),
    .i_accepted   (o_res.accepted)
);
